@@ sv/stereo_trim_saturate_dither_macros.svh @@
// Assertion macros for the checker file.
`ifndef STEREO_TRIM_SATURATE_DITHER_MACROS_SVH
`define STEREO_TRIM_SATURATE_DITHER_MACROS_SVH

// Same-cycle implication, held off while in reset.
`define STSD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off while in reset.
`define STSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/stsd_pkg.sv @@
// Shared constants and helpers for the stereo trim / soft clip / dither block.
`default_nettype none
package stsd_pkg;

  localparam int DEF_MAX_BLOCK   = 4096;
  localparam int DEF_SAMPLE_BITS = 24;

  localparam int GAIN_W     = 17;
  localparam int GAIN_FRAC  = 16;
  localparam int FL_W       = 12;
  localparam int BL_W       = 13;
  localparam int GUARD_BITS = 8;
  localparam int NOISE_W    = 32;

  localparam logic [GAIN_W-1:0] UNITY_GAIN = 17'h10000;

  localparam logic [NOISE_W-1:0] SEED_LEFT  = 32'h2545F491;
  localparam logic [NOISE_W-1:0] SEED_RIGHT = 32'h6C8E9CF5;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_TRIM_GAIN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DITHER_ENABLE = 2'd1;

  // one xorshift32 step, shifts 13, 17, 5
  function automatic logic [NOISE_W-1:0] xorshift32(input logic [NOISE_W-1:0] s);
    logic [NOISE_W-1:0] t;
    t = s ^ (s << 13);
    t = t ^ (t >> 17);
    t = t ^ (t << 5);
    return t;
  endfunction

endpackage
`default_nettype wire

@@ sv/stsd_mul.sv @@
// Shared signed multiplier with a registered product.
`default_nettype none
module stsd_mul #(
  parameter int W = 26
) (
  input  wire logic                  clk,
  input  wire logic signed [W-1:0]   a,
  input  wire logic signed [W-1:0]   b,
  output logic signed [2*W-1:0]      p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule
`default_nettype wire

@@ sv/stsd_div.sv @@
// Restoring divider, one quotient bit per cycle, for the gain ramp.
`default_nettype none
module stsd_div
  import stsd_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [GAIN_W+BL_W-1:0]   num,
  input  wire logic [BL_W-1:0]          den,
  output logic                          done,
  output logic [GAIN_W-1:0]             quo
);

  localparam int NW  = GAIN_W + BL_W;
  localparam int CW  = $clog2(GAIN_W + 1);

  logic [NW-1:0] rem;
  logic [NW-1:0] dsh;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          ge;

  // quotient is known to fit GAIN_W bits, so the divisor starts shifted by GAIN_W-1
  assign ge = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(GAIN_W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dsh <= NW'(den) << (GAIN_W - 1);
      quo <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      dsh <= dsh >> 1;
      quo <= {quo[GAIN_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

@@ sv/stsd_noise.sv @@
// Per-channel xorshift32 noise generators.
`default_nettype none
module stsd_noise
  import stsd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                adv,
  output logic [NOISE_W-1:0]       left_state,
  output logic [NOISE_W-1:0]       right_state
);

  always_ff @(posedge clk) begin
    if (rst) begin
      left_state  <= SEED_LEFT;
      right_state <= SEED_RIGHT;
    end else if (adv) begin
      left_state  <= xorshift32(left_state);
      right_state <= xorshift32(right_state);
    end
  end

endmodule
`default_nettype wire

@@ sv/stereo_trim_saturate_dither.sv @@
// Top level: gain ramp, soft clip and dither sequenced over a shared multiplier.
//
//   channel  signals                                   direction  handshake
//   in       sample_left/right, first_in_block,        into block valid/stall
//            frames_left, block_length
//   out      out_left, out_right                       out of     valid/stall
//   cfg      cfg_write_en, cfg_index, cfg_data         into block write only
//
// For each frame, three multiply steps build the ramp numerator,
// the 17-step divider forms the frame gain, then each channel takes four steps
// through the shared multiplier (scale, clamp, shape, dither and saturate).
// Synchronous active-high reset restores unity gains, dither on and the seeds.
// A result waits in the output register under stall; the next word is taken
// meanwhile and holds in its last step until the output register frees.
`default_nettype none
module stereo_trim_saturate_dither
  import stsd_pkg::*;
#(
  parameter int MAX_BLOCK   = DEF_MAX_BLOCK,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_left,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_right,
  input  wire logic                          first_in_block,
  input  wire logic [FL_W-1:0]               frames_left,
  input  wire logic [BL_W-1:0]               block_length,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0]      out_left,
  output logic signed [SAMPLE_BITS-1:0]      out_right,
  input  wire logic                          cfg_write_en,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data
);

  localparam int F  = SAMPLE_BITS - 1;
  localparam int MW = SAMPLE_BITS + 2;
  localparam int PW = 2 * MW;
  localparam int YW = SAMPLE_BITS + 1;
  localparam int NW = GAIN_W + BL_W;

  localparam logic signed [PW-1:0] ONE_P     = PW'(1) << F;
  localparam logic signed [PW-1:0] NEG_ONE_P = -(PW'(1) << F);
  localparam logic signed [PW-1:0] MAX_OUT_P = (PW'(1) << F) - PW'(1);
  localparam logic signed [MW-1:0] TWO_M     = MW'(1) << SAMPLE_BITS;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_NUM0  = 4'd1;
  localparam logic [3:0] S_NUM1  = 4'd2;
  localparam logic [3:0] S_NUM2  = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_DIVW  = 4'd5;
  localparam logic [3:0] S_SCALE = 4'd6;
  localparam logic [3:0] S_CLAMP = 4'd7;
  localparam logic [3:0] S_SHAPE = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0]   state;
  logic [3:0]   state_next;
  logic         ch;

  logic [GAIN_W-1:0] trim_gain;
  logic              dither_enable;
  logic [GAIN_W-1:0] previous_gain;
  logic [GAIN_W-1:0] target_gain;
  logic [GAIN_W-1:0] gain;

  logic [BL_W-1:0] fl_r;
  logic [BL_W-1:0] bl_r;
  logic [BL_W-1:0] span_r;
  logic [NW-1:0]   num;

  logic signed [SAMPLE_BITS-1:0] x_left;
  logic signed [SAMPLE_BITS-1:0] x_right;
  logic signed [YW-1:0]          y;
  logic signed [SAMPLE_BITS-1:0] res_left;
  logic signed [SAMPLE_BITS-1:0] res_right;

  logic in_accept;
  logic div_start;
  logic div_done;
  logic [GAIN_W-1:0] div_quo;

  logic [BL_W-1:0] bl_nz;
  logic [BL_W-1:0] bl_sat;
  logic [BL_W-1:0] fl_sat;

  logic signed [MW-1:0] mul_a;
  logic signed [MW-1:0] mul_b;
  logic signed [PW-1:0] prod;

  logic [NOISE_W-1:0]   left_noise_state;
  logic [NOISE_W-1:0]   right_noise_state;
  logic [NOISE_W-1:0]   noise_word;
  logic signed [8:0]    noise;

  logic signed [PW-1:0] y_wide;
  logic signed [PW-1:0] y_clamped;
  logic signed [MW-1:0] shape_m;
  logic signed [PW-1:0] shaped;
  logic signed [PW-1:0] dithered;
  logic signed [PW-1:0] trunc;
  logic signed [PW-1:0] sat;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign div_start = (state == S_DIV);

  // block length: zero reads as one, long blocks saturate; frames_left capped to it
  always_comb begin
    bl_nz  = (block_length == '0) ? BL_W'(1) : block_length;
    bl_sat = (32'(bl_nz) > MAX_BLOCK) ? BL_W'(MAX_BLOCK) : bl_nz;
    fl_sat = (BL_W'(frames_left) > bl_sat) ? bl_sat : BL_W'(frames_left);
  end

  stsd_mul #(.W(MW)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  stsd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (bl_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  stsd_noise u_noise (
    .clk         (clk),
    .rst         (rst),
    .adv         (in_accept),
    .left_state  (left_noise_state),
    .right_state (right_noise_state)
  );

  // y*(2-y) above zero, y*(y+2) below; zero gives zero either way
  assign shape_m = y[YW-1] ? (MW'(y) + TWO_M) : (TWO_M - MW'(y));

  always_comb begin
    case (state)
      S_NUM0: begin
        mul_a = $signed(MW'(previous_gain));
        mul_b = $signed(MW'(fl_r));
      end
      S_NUM1: begin
        mul_a = $signed(MW'(target_gain));
        mul_b = $signed(MW'(span_r));
      end
      S_SCALE: begin
        mul_a = ch ? MW'(x_right) : MW'(x_left);
        mul_b = $signed(MW'(gain));
      end
      S_SHAPE: begin
        mul_a = MW'(y);
        mul_b = shape_m;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // top nine generator bits, centred: value - 256 is the MSB inverted
  assign noise_word = ch ? right_noise_state : left_noise_state;
  assign noise      = $signed({~noise_word[NOISE_W-1], noise_word[NOISE_W-2:NOISE_W-9]});

  always_comb begin
    y_wide = prod >>> GAIN_FRAC;
    if (y_wide > ONE_P) begin
      y_clamped = ONE_P;
    end else if (y_wide < NEG_ONE_P) begin
      y_clamped = NEG_ONE_P;
    end else begin
      y_clamped = y_wide;
    end
    shaped   = prod >>> (F - GUARD_BITS);
    dithered = shaped + (dither_enable ? PW'(noise) : PW'(0));
    trunc    = dithered >>> GUARD_BITS;
    if (trunc > MAX_OUT_P) begin
      sat = MAX_OUT_P;
    end else if (trunc < NEG_ONE_P) begin
      sat = NEG_ONE_P;
    end else begin
      sat = trunc;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_accept) state_next = S_NUM0;
      S_NUM0:  state_next = S_NUM1;
      S_NUM1:  state_next = S_NUM2;
      S_NUM2:  state_next = S_DIV;
      S_DIV:   state_next = S_DIVW;
      S_DIVW:  if (div_done) state_next = S_SCALE;
      S_SCALE: state_next = S_CLAMP;
      S_CLAMP: state_next = S_SHAPE;
      S_SHAPE: state_next = S_FIN;
      S_FIN:   state_next = ch ? S_OUT : S_SCALE;
      S_OUT:   if (!out_valid || !out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      ch            <= 1'b0;
      out_valid     <= 1'b0;
      trim_gain     <= UNITY_GAIN;
      dither_enable <= 1'b1;
      previous_gain <= UNITY_GAIN;
      target_gain   <= UNITY_GAIN;
    end else begin
      state <= state_next;
      if (cfg_write_en) begin
        case (cfg_index)
          REG_TRIM_GAIN:     trim_gain <= (cfg_data > UNITY_GAIN) ? UNITY_GAIN : cfg_data;
          REG_DITHER_ENABLE: dither_enable <= cfg_data[0];
          default:           ;
        endcase
      end
      if (in_accept && first_in_block) begin
        previous_gain <= target_gain;
        target_gain   <= trim_gain;
      end
      if (state == S_DIVW) begin
        ch <= 1'b0;
      end else if (state == S_FIN) begin
        ch <= ~ch;
      end
      if (state == S_OUT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      x_left  <= sample_left;
      x_right <= sample_right;
      fl_r    <= fl_sat;
      bl_r    <= bl_sat;
      span_r  <= bl_sat - fl_sat;
    end
    case (state)
      S_NUM1:  num <= prod[NW-1:0];
      S_NUM2:  num <= num + prod[NW-1:0];
      S_CLAMP: y   <= $signed(y_clamped[YW-1:0]);
      S_FIN: begin
        if (ch) begin
          res_right <= $signed(sat[SAMPLE_BITS-1:0]);
        end else begin
          res_left <= $signed(sat[SAMPLE_BITS-1:0]);
        end
      end
      default: ;
    endcase
    if (state == S_DIVW && div_done) begin
      gain <= div_quo;
    end
    if (state == S_OUT && (!out_valid || !out_stall)) begin
      out_left  <= res_left;
      out_right <= res_right;
    end
  end

endmodule
`default_nettype wire

@@ sv/stsd_checker.sv @@
// Port-level checks for the top level, bound in below.
`default_nettype none
`include "stereo_trim_saturate_dither_macros.svh"
module stsd_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   in_valid,
  input wire logic                   in_stall,
  input wire logic                   out_valid,
  input wire logic                   out_stall,
  input wire logic [SAMPLE_BITS-1:0] out_left,
  input wire logic [SAMPLE_BITS-1:0] out_right
);

  `STSD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_left) && $stable(out_right), "stalled output word changed")

  `STSD_ASSERT_NEXT(a_busy_after_take, clk, rst, in_valid && !in_stall, in_stall, "input taken again straight after a word")

  `STSD_ASSERT_NEXT(a_no_instant_result, clk, rst, in_valid && !in_stall, !$rose(out_valid), "result appeared one cycle after input")

  `STSD_ASSERT_IMPLY(a_reset_state, clk, rst, $past(rst), !out_valid && !in_stall, "block not idle after reset")

endmodule

bind stereo_trim_saturate_dither stsd_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_stsd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_left  (out_left),
  .out_right (out_right)
);
`default_nettype wire
